// ===== design/knc_pkg.sv =====
// Shared types and constants for the nearest-to-center selection block.
// Depends on nothing; every other design file refers to it by scoped names.

package knc_pkg;

   // Fixed field widths of the ports
   localparam int COORD_W    = 24;
   localparam int KEEP_W     = 7;
   localparam int INDEX_W    = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 3 * COORD_W;

   // Parameter defaults
   localparam int MAX_KEEP_DEF   = 64;
   localparam int MAX_POINTS_DEF = 65536;
   localparam int COORD_BITS_DEF = 24;

   // Configuration register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_CENTER_X   = 2'd0,
      REG_CENTER_Y   = 2'd1,
      REG_CENTER_Z   = 2'd2,
      REG_KEEP_COUNT = 2'd3
   } csr_reg_type;

   // Operation applied to every cell of the sorted chain in the same cycle
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_APPEND = 2'd1,
      OP_EVICT  = 2'd2,
      OP_SHIFT  = 2'd3
   } chain_op_type;

endpackage

// ===== design/k_nearest_to_center_select.sv =====
// After the last point of a pass leaves the distance pipe, the kept indices
// drain through the result register, one a cycle while rsp_tready stays high.
// Throughput: one point per cycle through the distance pipe and sorted chain;
// after a last point, input stalls while the kept indices drain, also when
// none is kept, and for longer while rsp_tready is low.
// Synchronous active-high reset clears config, counters, flags.

module k_nearest_to_center_select #(
   parameter int MAX_KEEP   = knc_pkg::MAX_KEEP_DEF,
   parameter int MAX_POINTS = knc_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = knc_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // Input words
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [knc_pkg::REQ_DATA_W-1:0] req_tdata,  // pos_x, pos_y, pos_z
   input  logic                           req_tlast,  // last_point
   // Result words
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [knc_pkg::INDEX_W-1:0]    rsp_tdata,  // vertex_index
   output logic                           rsp_tlast,  // last_of_run
   // Configuration writes
   input  logic                           csr_wr_en,
   input  logic [knc_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [knc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int C      = COORD_BITS;
   localparam int DIST_W = 2 * C + 2;
   localparam int IDX_W  = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int TOT_W  = $clog2(MAX_KEEP + 1);
   localparam int CW     = knc_pkg::COORD_W;
   localparam int KW     = knc_pkg::KEEP_W;

   typedef enum logic {
      ST_RUN   = 1'b0,
      ST_DRAIN = 1'b1
   } state_type;

   state_type state_ff, state_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_last_ff, rsp_last_in;
   logic [knc_pkg::INDEX_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CW-1:0] center_x_ff, center_y_ff, center_z_ff;
   logic [KW-1:0] keep_ff;
   logic [IDX_W-1:0] count_ff;

   logic advance, accept, apply, room, evict;
   logic [KW-1:0] limit;
   knc_pkg::chain_op_type op;

   logic s3_valid, s3_last;
   logic [DIST_W-1:0] s3_dist;
   logic [IDX_W-1:0] s3_idx;

   logic [DIST_W-1:0] cell_dist [MAX_KEEP];
   logic [IDX_W-1:0]  cell_idx  [MAX_KEEP];
   logic              cell_gt   [MAX_KEEP];

   assign advance    = (state_ff == ST_RUN);
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;
   assign apply      = advance && s3_valid;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         keep_ff     <= '0;
      end else if (csr_wr_en) begin
         unique case (knc_pkg::csr_reg_type'(csr_index))
            knc_pkg::REG_CENTER_X:   center_x_ff <= csr_wdata[CW-1:0];
            knc_pkg::REG_CENTER_Y:   center_y_ff <= csr_wdata[CW-1:0];
            knc_pkg::REG_CENTER_Z:   center_z_ff <= csr_wdata[CW-1:0];
            knc_pkg::REG_KEEP_COUNT: keep_ff     <= csr_wdata[KW-1:0];
            default:                 keep_ff     <= keep_ff;
         endcase
      end
   end

   // Number points in arrival order; restart after the last point or after MAX_POINTS points
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         if (req_tlast || (count_ff == IDX_W'(MAX_POINTS - 1))) begin
            count_ff <= '0;
         end else begin
            count_ff <= count_ff + IDX_W'(1);
         end
      end
   end

   knc_dist #(
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W),
      .DIST_W     (DIST_W)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (accept),
      .pos_x     (req_tdata[CW-1:0]),
      .pos_y     (req_tdata[2*CW-1:CW]),
      .pos_z     (req_tdata[3*CW-1:2*CW]),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .center_z  (center_z_ff),
      .idx_in    (count_ff),
      .last_in   (req_tlast),
      .out_valid (s3_valid),
      .dist_out  (s3_dist),
      .idx_out   (s3_idx),
      .last_out  (s3_last)
   );

   // Sorted chain, farthest entry in cell 0
   for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
      logic [DIST_W-1:0] l_dist, r_dist;
      logic [IDX_W-1:0]  l_idx, r_idx;
      logic              l_gt, r_gt;
      if (i == 0) begin : g_head
         assign l_dist = '0;
         assign l_idx  = '0;
         assign l_gt   = 1'b1;
      end else begin : g_body
         assign l_dist = cell_dist[i-1];
         assign l_idx  = cell_idx[i-1];
         assign l_gt   = cell_gt[i-1];
      end
      if (i == MAX_KEEP - 1) begin : g_tail
         assign r_dist = '0;
         assign r_idx  = '0;
         assign r_gt   = 1'b0;
      end else begin : g_next
         assign r_dist = cell_dist[i+1];
         assign r_idx  = cell_idx[i+1];
         assign r_gt   = cell_gt[i+1];
      end
      knc_cell #(
         .DIST_W (DIST_W),
         .IDX_W  (IDX_W),
         .TOT_W  (TOT_W),
         .INDEX  (i)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .total      (total_ff),
         .new_dist   (s3_dist),
         .new_idx    (s3_idx),
         .left_dist  (l_dist),
         .left_idx   (l_idx),
         .left_gt    (l_gt),
         .right_dist (r_dist),
         .right_idx  (r_idx),
         .right_gt   (r_gt),
         .dist_out   (cell_dist[i]),
         .idx_out    (cell_idx[i]),
         .gt_out     (cell_gt[i])
      );
   end

   // Append below the limit, else replace the farthest if strictly closer
   always_comb begin
      limit = (keep_ff > KW'(MAX_KEEP)) ? KW'(MAX_KEEP) : keep_ff;
      room  = KW'(total_ff) < limit;
      evict = (total_ff != '0) && !room && (s3_dist < cell_dist[0]);
   end

   // Pass control and result register
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      op           = knc_pkg::OP_HOLD;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (apply) begin
               if (room) begin
                  op       = knc_pkg::OP_APPEND;
                  total_in = total_ff + TOT_W'(1);
               end else if (evict) begin
                  op = knc_pkg::OP_EVICT;
               end
               if (s3_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (total_ff == '0) begin
               state_in = ST_RUN;
            end else if (!rsp_valid_ff || rsp_tready) begin
               // Emit the farthest entry and shift the chain up
               op           = knc_pkg::OP_SHIFT;
               rsp_valid_in = 1'b1;
               rsp_data_in  = knc_pkg::INDEX_W'(cell_idx[0]);
               rsp_last_in  = (total_ff == TOT_W'(1));
               total_in     = total_ff - TOT_W'(1);
               if (total_ff == TOT_W'(1)) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== design/knc_dist.sv =====
// Three-stage squared-distance pipeline: difference, square, sum.
// Depends on knc_pkg for the port field widths.

module knc_dist #(
   parameter int COORD_BITS = knc_pkg::COORD_BITS_DEF,
   parameter int IDX_W      = 16,
   parameter int DIST_W     = 2 * COORD_BITS + 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [knc_pkg::COORD_W-1:0] pos_x,
   input  logic [knc_pkg::COORD_W-1:0] pos_y,
   input  logic [knc_pkg::COORD_W-1:0] pos_z,
   input  logic [knc_pkg::COORD_W-1:0] center_x,
   input  logic [knc_pkg::COORD_W-1:0] center_y,
   input  logic [knc_pkg::COORD_W-1:0] center_z,
   input  logic [IDX_W-1:0]            idx_in,
   input  logic                        last_in,
   output logic                        out_valid,
   output logic [DIST_W-1:0]           dist_out,
   output logic [IDX_W-1:0]            idx_out,
   output logic                        last_out
);

   localparam int C = COORD_BITS;

   logic signed [C:0] px, py, pz, cx, cy, cz;
   logic signed [C:0] dx_in, dy_in, dz_in;
   logic signed [C:0] dx_ff, dy_ff, dz_ff;
   logic signed [DIST_W-1:0] sqx_in, sqy_in, sqz_in;
   logic [DIST_W-1:0] sqx_ff, sqy_ff, sqz_ff;
   logic [DIST_W-1:0] sum_in, sum_ff;
   logic v1_ff, v2_ff, v3_ff;
   logic l1_ff, l2_ff, l3_ff;
   logic [IDX_W-1:0] i1_ff, i2_ff, i3_ff;

   // Sign-extend the low coordinate bits, take the differences, and square and sum the stage values
   always_comb begin
      px = {pos_x[C-1], pos_x[C-1:0]};
      py = {pos_y[C-1], pos_y[C-1:0]};
      pz = {pos_z[C-1], pos_z[C-1:0]};
      cx = {center_x[C-1], center_x[C-1:0]};
      cy = {center_y[C-1], center_y[C-1:0]};
      cz = {center_z[C-1], center_z[C-1:0]};
      dx_in = px - cx;
      dy_in = py - cy;
      dz_in = pz - cz;
      sqx_in = DIST_W'(dx_ff) * DIST_W'(dx_ff);
      sqy_in = DIST_W'(dy_ff) * DIST_W'(dy_ff);
      sqz_in = DIST_W'(dz_ff) * DIST_W'(dz_ff);
      sum_in = sqx_ff + sqy_ff + sqz_ff;
   end

   // Stage valids advance together with the whole pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         dz_ff  <= dz_in;
         i1_ff  <= idx_in;
         l1_ff  <= last_in;
         sqx_ff <= DIST_W'(sqx_in);
         sqy_ff <= DIST_W'(sqy_in);
         sqz_ff <= DIST_W'(sqz_in);
         i2_ff  <= i1_ff;
         l2_ff  <= l1_ff;
         sum_ff <= sum_in;
         i3_ff  <= i2_ff;
         l3_ff  <= l2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign dist_out  = sum_ff;
   assign idx_out   = i3_ff;
   assign last_out  = l3_ff;

endmodule

// ===== design/knc_cell.sv =====
// One cell of the sorted chain: holds one kept (distance, index) entry.
// Depends on knc_pkg for the chain operation type.

module knc_cell #(
   parameter int DIST_W = 50,
   parameter int IDX_W  = 16,
   parameter int TOT_W  = 7,
   parameter int INDEX  = 0
) (
   input  logic                  clock,
   input  knc_pkg::chain_op_type op,
   input  logic [TOT_W-1:0]      total,
   input  logic [DIST_W-1:0]     new_dist,
   input  logic [IDX_W-1:0]      new_idx,
   input  logic [DIST_W-1:0]     left_dist,
   input  logic [IDX_W-1:0]      left_idx,
   input  logic                  left_gt,
   input  logic [DIST_W-1:0]     right_dist,
   input  logic [IDX_W-1:0]      right_idx,
   input  logic                  right_gt,
   output logic [DIST_W-1:0]     dist_out,
   output logic [IDX_W-1:0]      idx_out,
   output logic                  gt_out
);

   localparam logic [TOT_W-1:0] MY_POS = TOT_W'(INDEX);

   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              occupied;
   logic              key_gt;

   // Entry ranks above the new point by (distance, index)
   always_comb begin
      occupied = total > MY_POS;
      key_gt   = (dist_ff > new_dist) || ((dist_ff == new_dist) && (idx_ff > new_idx));
      gt_out   = occupied && key_gt;
   end

   // Pick the next entry from self, the new point or a neighbor
   always_comb begin
      dist_in = dist_ff;
      idx_in  = idx_ff;
      case (op)
         knc_pkg::OP_APPEND: begin
            if (!gt_out) begin
               if (left_gt) begin
                  dist_in = new_dist;
                  idx_in  = new_idx;
               end else begin
                  dist_in = left_dist;
                  idx_in  = left_idx;
               end
            end
         end
         knc_pkg::OP_EVICT: begin
            if (right_gt) begin
               dist_in = right_dist;
               idx_in  = right_idx;
            end else if (gt_out) begin
               dist_in = new_dist;
               idx_in  = new_idx;
            end
         end
         knc_pkg::OP_SHIFT: begin
            dist_in = right_dist;
            idx_in  = right_idx;
         end
         default: begin
            dist_in = dist_ff;
            idx_in  = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      idx_ff  <= idx_in;
   end

   assign dist_out = dist_ff;
   assign idx_out  = idx_ff;

endmodule

// ===== design/knc_checker.sv =====
// Port-level checks for the nearest-to-center selection block, bound to its top.
// Depends on knc_pkg for widths and on the top level's port names.

module knc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [knc_pkg::INDEX_W-1:0]    rsp_tdata,
   input logic                           rsp_tlast
);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // Input stays closed while a pass still has words to deliver
   a_drain_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input open during result drain");

   // Reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A non-final word is followed at once by the next word of the same pass
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("pass ended without a final word");

endmodule

bind k_nearest_to_center_select knc_checker u_knc_checker (.*);
